// File: rtl/fmc_pkg.sv
// Shared types and constants for the flow metering cache.
// Holds the entry and result layouts, the command and status structs and the state enum.
`timescale 1ns / 1ps
package fmc_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [31:0] IDLE_TIMEOUT_RST     = 32'd10000;
  localparam logic [31:0] ACTIVE_TIMEOUT_RST   = 32'd30000;
  localparam logic [31:0] TEMPLATE_INTERVAL_RST = 32'd10000;

  localparam logic [1:0] REG_IDLE_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_ACTIVE_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_TEMPLATE_INTERVAL = 2'd2;

  localparam logic [1:0] RES_IDLE     = 2'd0;
  localparam logic [1:0] RES_ACTIVE   = 2'd1;
  localparam logic [1:0] RES_TEMPLATE = 2'd2;
  localparam logic [1:0] RES_FULL     = 2'd3;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic [31:0] octets;
    logic [31:0] packets;
    logic [47:0] end_ms;
    logic [47:0] start_ms;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [7:0]  protocol;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0] kind;
    entry_t     ent;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_SCAN,
    ST_P_CMP,
    ST_P_END,
    ST_T_TMPL,
    ST_T_SCAN,
    ST_T_CMP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic idx_inc;
    logic note_free;
    logic rd_issue;
    logic hit_write;
    logic alloc_write;
    logic full_take;
    logic tmpl_take;
    logic exp_take;
    logic push;
    logic push_last;
  } cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic idx_last;
    logic hit;
    logic idle_exp;
    logic active_exp;
    logic tmpl_due;
    logic free_found;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/fmc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module fmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fmc_ctrl.sv
// Controller of the flow metering cache: sequences lookups, allocation and tick scans.
// Uses fmc_pkg; drives commands to fmc_dp and reads its status.
`timescale 1ns / 1ps
module fmc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  fmc_pkg::sts_t sts,
  output fmc_pkg::cmd_t cmd
);

  fmc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      fmc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = (in_kind == fmc_pkg::KIND_TICK) ? fmc_pkg::ST_T_TMPL
                                                        : fmc_pkg::ST_P_SCAN;
        end
      end
      fmc_pkg::ST_P_SCAN: begin
        if (sts.cur_valid) begin
          cmd.rd_issue = 1'b1;
          state_next = fmc_pkg::ST_P_CMP;
        end else begin
          cmd.note_free = 1'b1;
          if (sts.idx_last) begin
            state_next = fmc_pkg::ST_P_END;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      fmc_pkg::ST_P_CMP: begin
        if (sts.hit) begin
          cmd.hit_write = 1'b1;
          state_next = fmc_pkg::ST_IDLE;
        end else if (sts.idx_last) begin
          state_next = fmc_pkg::ST_P_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = fmc_pkg::ST_P_SCAN;
        end
      end
      fmc_pkg::ST_P_END: begin
        if (sts.free_found) begin
          cmd.alloc_write = 1'b1;
          state_next = fmc_pkg::ST_IDLE;
        end else begin
          cmd.full_take = 1'b1;
          state_next = fmc_pkg::ST_FLUSH;
        end
      end
      fmc_pkg::ST_T_TMPL: begin
        cmd.tmpl_take = sts.tmpl_due;
        state_next = fmc_pkg::ST_T_SCAN;
      end
      fmc_pkg::ST_T_SCAN: begin
        if (sts.cur_valid) begin
          cmd.rd_issue = 1'b1;
          state_next = fmc_pkg::ST_T_CMP;
        end else if (sts.idx_last) begin
          state_next = fmc_pkg::ST_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      fmc_pkg::ST_T_CMP: begin
        if ((sts.idle_exp || sts.active_exp) && sts.pend_valid && !sts.out_free) begin
          state_next = fmc_pkg::ST_T_CMP;
        end else begin
          if (sts.idle_exp || sts.active_exp) begin
            cmd.exp_take = 1'b1;
            cmd.push = sts.pend_valid;
          end
          if (sts.idx_last) begin
            state_next = fmc_pkg::ST_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next = fmc_pkg::ST_T_SCAN;
          end
        end
      end
      fmc_pkg::ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = fmc_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push = 1'b1;
          cmd.push_last = 1'b1;
          state_next = fmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fmc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/fmc_dp.sv
// Datapath of the flow metering cache: entry RAM, valid bits, registers and result staging.
// Uses fmc_pkg and fmc_ram; takes commands from fmc_ctrl.
`timescale 1ns / 1ps
module fmc_dp #(
  parameter int FLOW_ENTRIES = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [31:0]   cfg_wdata,
  input  logic [167:0]  in_data,
  input  fmc_pkg::cmd_t cmd,
  output fmc_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output fmc_pkg::rec_t out_rec,
  output logic          out_last
);

  localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  logic [31:0] idle_timeout;
  logic [31:0] active_timeout;
  logic [31:0] template_interval;
  logic [47:0] last_tmpl;

  fmc_pkg::entry_t key;
  logic [47:0]     in_now;
  logic [15:0]     in_len;

  logic [IW-1:0]           idx;
  logic [IW-1:0]           free_idx;
  logic                    free_found;
  logic [FLOW_ENTRIES-1:0] entry_valid;

  fmc_pkg::rec_t   pend;
  logic            pend_valid;
  fmc_pkg::entry_t rdata;
  fmc_pkg::entry_t wdata;
  fmc_pkg::entry_t hit_ent;
  fmc_pkg::entry_t new_ent;
  fmc_pkg::entry_t restart_ent;
  logic            ram_we;
  logic [IW-1:0]   waddr;
  logic            ports_kept;
  logic [32:0]     pkt_sum;
  logic [32:0]     oct_sum;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= fmc_pkg::IDLE_TIMEOUT_RST;
      active_timeout <= fmc_pkg::ACTIVE_TIMEOUT_RST;
      template_interval <= fmc_pkg::TEMPLATE_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        fmc_pkg::REG_IDLE_TIMEOUT:      idle_timeout <= cfg_wdata;
        fmc_pkg::REG_ACTIVE_TIMEOUT:    active_timeout <= cfg_wdata;
        fmc_pkg::REG_TEMPLATE_INTERVAL: template_interval <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ports_kept = (in_data[71:64] == fmc_pkg::PROTO_TCP) ||
                      (in_data[71:64] == fmc_pkg::PROTO_UDP);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key.src_ip <= in_data[31:0];
      key.dst_ip <= in_data[63:32];
      key.protocol <= in_data[71:64];
      key.sport <= ports_kept ? in_data[87:72] : 16'd0;
      key.dport <= ports_kept ? in_data[103:88] : 16'd0;
      key.start_ms <= in_data[167:120];
      key.end_ms <= in_data[167:120];
      key.packets <= 32'd1;
      key.octets <= {16'd0, in_data[119:104]};
      in_len <= in_data[119:104];
      in_now <= in_data[167:120];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      free_idx <= '0;
      free_found <= 1'b0;
    end else if (cmd.load_in) begin
      idx <= '0;
      free_found <= 1'b0;
    end else begin
      if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.note_free && !free_found) begin
        free_idx <= idx;
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.alloc_write) begin
      entry_valid[free_idx] <= 1'b1;
    end else if (cmd.exp_take && sts.idle_exp) begin
      entry_valid[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tmpl <= '0;
    end else if (cmd.tmpl_take) begin
      last_tmpl <= in_now;
    end
  end

  assign pkt_sum = {1'b0, rdata.packets} + 33'd1;
  assign oct_sum = {1'b0, rdata.octets} + {17'd0, in_len};

  always_comb begin
    hit_ent = rdata;
    hit_ent.end_ms = in_now;
    hit_ent.packets = pkt_sum[32] ? 32'hFFFF_FFFF : pkt_sum[31:0];
    hit_ent.octets = oct_sum[32] ? 32'hFFFF_FFFF : oct_sum[31:0];
    restart_ent = rdata;
    restart_ent.start_ms = in_now;
    restart_ent.end_ms = in_now;
    restart_ent.packets = '0;
    restart_ent.octets = '0;
    new_ent = key;
  end

  assign ram_we = cmd.hit_write || cmd.alloc_write ||
                  (cmd.exp_take && !sts.idle_exp);
  assign waddr = cmd.alloc_write ? free_idx : idx;
  assign wdata = cmd.hit_write ? hit_ent : (cmd.alloc_write ? new_ent : restart_ent);

  fmc_ram #(
    .WIDTH (fmc_pkg::ENTRY_W),
    .DEPTH (FLOW_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_issue),
    .raddr (idx),
    .rdata (rdata)
  );

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.full_take || cmd.tmpl_take || cmd.exp_take) begin
      pend_valid <= 1'b1;
    end else if (cmd.push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.full_take) begin
      pend.kind <= fmc_pkg::RES_FULL;
      pend.ent <= key;
    end else if (cmd.tmpl_take) begin
      pend.kind <= fmc_pkg::RES_TEMPLATE;
      pend.ent <= '0;
    end else if (cmd.exp_take) begin
      pend.kind <= sts.idle_exp ? fmc_pkg::RES_IDLE : fmc_pkg::RES_ACTIVE;
      pend.ent <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_rec <= pend;
      out_last <= cmd.push_last;
    end
  end

  assign sts.cur_valid = entry_valid[idx];
  assign sts.idx_last = (idx == IW'(FLOW_ENTRIES - 1));
  assign sts.hit = (rdata.src_ip == key.src_ip) && (rdata.dst_ip == key.dst_ip) &&
                   (rdata.protocol == key.protocol) && (rdata.sport == key.sport) &&
                   (rdata.dport == key.dport);
  assign sts.idle_exp = ({1'b0, rdata.end_ms} + {17'd0, idle_timeout}) < {1'b0, in_now};
  assign sts.active_exp = ({1'b0, rdata.start_ms} + {17'd0, active_timeout}) <
                          {1'b0, in_now};
  assign sts.tmpl_due = ({1'b0, last_tmpl} + {17'd0, template_interval}) < {1'b0, in_now};
  assign sts.free_found = free_found;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free = out_free;

endmodule

// File: rtl/flow_metering_cache.sv
// Top level of the flow metering cache: IPv4 flow table with idle and active expiry.
// Uses fmc_pkg, fmc_ctrl and fmc_dp (which holds the fmc_ram entry store).
//
// Channel   Dir  Handshake          Content
// s_axis    in   tvalid / tready    tuser kind, tdata packet fields and time
// m_axis    out  tvalid / tready    tuser result kind, tlast, tdata flow record
// cfg       in   cfg_we             cfg_addr register index, cfg_wdata value
//
// One item is worked on at a time; entries are visited through the single read port of the
// entry RAM. A packet visits each valid entry in a scan state and a compare state, and each
// free one in the scan state alone; a tick first checks the template interval in its own state,
// and each result waits while the output register is still full.
// Reset clears all valid bits at once; there is no clearing pass.
`timescale 1ns / 1ps
module flow_metering_cache #(
  parameter int FLOW_ENTRIES = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // src_ip, dst_ip, protocol, source port, destination port, ip_length, now_ms
  input  logic [167:0] s_tdata,
  // kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rec_src_ip, rec_dst_ip, rec_protocol, record source port, record destination port,
  // rec_start_ms, rec_end_ms, rec_packets, rec_octets
  output logic [263:0] m_tdata,
  // result_kind
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  fmc_pkg::cmd_t cmd;
  fmc_pkg::sts_t sts;
  fmc_pkg::rec_t out_rec;

  fmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fmc_dp #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec),
    .out_last  (m_tlast)
  );

  assign m_tdata = out_rec.ent;
  assign m_tuser = out_rec.kind;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.out_free)
    else $error("result pushed into a full output register");

  a_tmpl_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fmc_pkg::RES_TEMPLATE |-> m_tdata == '0)
    else $error("template result carries nonzero record");

  a_full_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == fmc_pkg::RES_FULL |-> m_tlast)
    else $error("table full result not marked last");

  a_reset_ready: assert property (@(posedge clk)
    !rst && $past(rst) |-> s_tready)
    else $error("input not ready after reset");

endmodule
